[rtl/core/owm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the 1-Wire bus master sequencer.
// ----------------------------------------------------------------------------
package owm_pkg;

	localparam int ScratchBytesDefault = 9;
	localparam int NumRegs             = 7;

	localparam logic [7:0] RESET_LEAD_TICKS = 8'd5;
	localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
	localparam logic [7:0] CMD_CONVERT      = 8'h44;
	localparam logic [7:0] CMD_READ_SP      = 8'hBE;
	localparam logic [7:0] SAMPLE_MSB       = 8'h80;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_RESET = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ  = 3'd3,
		OP_XACT  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_RESET_LOW     = 3'd0,
		REG_PRESENCE_WAIT = 3'd1,
		REG_RESET_TAIL    = 3'd2,
		REG_READ_SAMPLE   = 3'd3,
		REG_READ_TAIL     = 3'd4,
		REG_SHORT_LOW     = 3'd5,
		REG_LONG_LOW      = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LEAD = 4'd1,
		PH_RST_LOW  = 4'd2,
		PH_RST_WAIT = 4'd3,
		PH_RST_TAIL = 4'd4,
		PH_WR_LOW   = 4'd5,
		PH_WR_HIGH  = 4'd6,
		PH_RD_LOW   = 4'd7,
		PH_RD_WAIT  = 4'd8,
		PH_RD_TAIL  = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		STEP_FIRST_SKIP = 3'd0,
		STEP_CONVERT    = 3'd1,
		STEP_RESET2     = 3'd2,
		STEP_SECOND_RST = 3'd3,
		STEP_READ_CMD   = 3'd4,
		STEP_START_RD   = 3'd5,
		STEP_READING    = 3'd6
	} step_t;

	typedef struct packed {
		logic [7:0] reset_low_ticks;
		logic [7:0] presence_wait_ticks;
		logic [7:0] reset_tail_ticks;
		logic [7:0] read_sample_ticks;
		logic [7:0] read_tail_ticks;
		logic [7:0] short_low_ticks;
		logic [7:0] long_low_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] tick_count;
		logic [2:0] bit_count;
		logic [7:0] shift_byte;
		logic [2:0] command_step;
		logic [3:0] bytes_read;
		logic [1:0] absent_flags;
		logic [2:0] active_operation;
	} state_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] write_data;
		logic       bus_level;
	} item_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       first_absent;
		logic       second_absent;
		logic [7:0] read_byte;
		logic       byte_valid;
		logic       last_byte;
	} res_t;

endpackage
`default_nettype wire

[rtl/core/owm_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owm_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module owm_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [7:0]    cfg_wdata,
	output owm_pkg::cfg_t      cfg
);

	owm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks     <= 8'd120;
			cfg_q.presence_wait_ticks <= 8'd15;
			cfg_q.reset_tail_ticks    <= 8'd20;
			cfg_q.read_sample_ticks   <= 8'd2;
			cfg_q.read_tail_ticks     <= 8'd11;
			cfg_q.short_low_ticks     <= 8'd2;
			cfg_q.long_low_ticks      <= 8'd10;
		end else if (cfg_we) begin
			case (owm_pkg::reg_idx_t'(cfg_index))
				owm_pkg::REG_RESET_LOW:     cfg_q.reset_low_ticks     <= cfg_wdata;
				owm_pkg::REG_PRESENCE_WAIT: cfg_q.presence_wait_ticks <= cfg_wdata;
				owm_pkg::REG_RESET_TAIL:    cfg_q.reset_tail_ticks    <= cfg_wdata;
				owm_pkg::REG_READ_SAMPLE:   cfg_q.read_sample_ticks   <= cfg_wdata;
				owm_pkg::REG_READ_TAIL:     cfg_q.read_tail_ticks     <= cfg_wdata;
				owm_pkg::REG_SHORT_LOW:     cfg_q.short_low_ticks     <= cfg_wdata;
				owm_pkg::REG_LONG_LOW:      cfg_q.long_low_ticks      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[rtl/core/owm_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owm_step
// One tick of the bus sequencer: next state and the result of the tick.
// ----------------------------------------------------------------------------
module owm_step #(
	parameter int SCRATCH_BYTES = owm_pkg::ScratchBytesDefault
) (
	input  owm_pkg::state_t st,
	input  owm_pkg::cfg_t   cfg,
	input  owm_pkg::item_t  item,
	output owm_pkg::state_t nxt,
	output owm_pkg::res_t   res
);

	owm_pkg::state_t ns;
	owm_pkg::res_t   r;
	logic [7:0]      len_raw;
	logic [7:0]      len;
	logic            fin;
	logic            last;
	logic [4:0]      read_sum;
	logic            busy;
	logic            drv;
	logic            done;
	logic            emit;
	logic            emit_last;
	logic [7:0]      emit_byte;

	// next state
	always_comb begin
		ns        = st;
		len_raw   = 8'd1;
		len       = 8'd1;
		fin       = 1'b0;
		last      = 1'b0;
		read_sum  = 5'd0;
		busy      = 1'b0;
		drv       = 1'b0;
		done      = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_byte = 8'd0;

		// command start while idle
		if (ns.phase == owm_pkg::PH_IDLE &&
		    (item.operation == owm_pkg::OP_RESET || item.operation == owm_pkg::OP_WRITE ||
		     item.operation == owm_pkg::OP_READ  || item.operation == owm_pkg::OP_XACT)) begin
			ns.active_operation = item.operation;
			ns.absent_flags     = 2'b00;
			ns.command_step     = owm_pkg::STEP_FIRST_SKIP;
			ns.bytes_read       = 4'd0;
			ns.tick_count       = 8'd0;
			case (owm_pkg::op_t'(item.operation))
				owm_pkg::OP_WRITE: begin
					ns.shift_byte = item.write_data;
					ns.bit_count  = 3'd0;
					ns.phase      = owm_pkg::PH_WR_LOW;
				end
				owm_pkg::OP_READ: begin
					ns.shift_byte = 8'd0;
					ns.bit_count  = 3'd0;
					ns.phase      = owm_pkg::PH_RD_LOW;
				end
				default: ns.phase = owm_pkg::PH_RST_LEAD;
			endcase
		end

		if (ns.phase != owm_pkg::PH_IDLE) begin
			busy = 1'b1;
			drv  = (ns.phase == owm_pkg::PH_RST_LOW) || (ns.phase == owm_pkg::PH_WR_LOW) ||
			       (ns.phase == owm_pkg::PH_RD_LOW);

			case (ns.phase)
				owm_pkg::PH_RST_LEAD: len_raw = owm_pkg::RESET_LEAD_TICKS;
				owm_pkg::PH_RST_LOW:  len_raw = cfg.reset_low_ticks;
				owm_pkg::PH_RST_WAIT: len_raw = cfg.presence_wait_ticks;
				owm_pkg::PH_RST_TAIL: len_raw = cfg.reset_tail_ticks;
				owm_pkg::PH_WR_LOW:   len_raw = ns.shift_byte[0] ? cfg.short_low_ticks
				                                                 : cfg.long_low_ticks;
				owm_pkg::PH_WR_HIGH:  len_raw = ns.shift_byte[0] ? cfg.long_low_ticks
				                                                 : cfg.short_low_ticks;
				owm_pkg::PH_RD_WAIT:  len_raw = cfg.read_sample_ticks;
				owm_pkg::PH_RD_TAIL:  len_raw = cfg.read_tail_ticks;
				default:              len_raw = 8'd1;
			endcase
			len = (len_raw == 8'd0) ? 8'd1 : len_raw;

			// presence sample
			if (ns.tick_count == 8'd0 && ns.phase == owm_pkg::PH_RST_TAIL && item.bus_level) begin
				if (ns.active_operation == owm_pkg::OP_XACT &&
				    ns.command_step == owm_pkg::STEP_SECOND_RST)
					ns.absent_flags[1] = 1'b1;
				else
					ns.absent_flags[0] = 1'b1;
			end
			// read bit sample
			if (ns.tick_count == 8'd0 && ns.phase == owm_pkg::PH_RD_TAIL)
				ns.shift_byte = (ns.shift_byte >> 1) | (item.bus_level ? owm_pkg::SAMPLE_MSB : 8'd0);

			ns.tick_count = ns.tick_count + 8'd1;
			if (ns.tick_count >= len) begin
				ns.tick_count = 8'd0;
				case (ns.phase)
					owm_pkg::PH_RST_LEAD: ns.phase = owm_pkg::PH_RST_LOW;
					owm_pkg::PH_RST_LOW:  ns.phase = owm_pkg::PH_RST_WAIT;
					owm_pkg::PH_RST_WAIT: ns.phase = owm_pkg::PH_RST_TAIL;
					owm_pkg::PH_WR_LOW:   ns.phase = owm_pkg::PH_WR_HIGH;
					owm_pkg::PH_RD_LOW:   ns.phase = owm_pkg::PH_RD_WAIT;
					owm_pkg::PH_RD_WAIT:  ns.phase = owm_pkg::PH_RD_TAIL;
					owm_pkg::PH_WR_HIGH: begin
						ns.shift_byte = ns.shift_byte >> 1;
						ns.bit_count  = ns.bit_count + 3'd1;
						if (ns.bit_count == 3'd0) fin = 1'b1;
						else ns.phase = owm_pkg::PH_WR_LOW;
					end
					owm_pkg::PH_RD_TAIL: begin
						ns.bit_count = ns.bit_count + 3'd1;
						if (ns.bit_count == 3'd0) fin = 1'b1;
						else ns.phase = owm_pkg::PH_RD_LOW;
					end
					default: fin = 1'b1;
				endcase
			end

			// end of a reset, byte write or byte read
			if (fin) begin
				if (ns.active_operation != owm_pkg::OP_XACT) begin
					if (ns.active_operation == owm_pkg::OP_READ) begin
						emit      = 1'b1;
						emit_byte = ns.shift_byte;
						emit_last = 1'b1;
					end
					ns.phase      = owm_pkg::PH_IDLE;
					ns.tick_count = 8'd0;
					done          = 1'b1;
				end else begin
					ns.tick_count = 8'd0;
					ns.bit_count  = 3'd0;
					case (ns.command_step)
						owm_pkg::STEP_FIRST_SKIP: begin
							ns.command_step = owm_pkg::STEP_CONVERT;
							ns.shift_byte   = owm_pkg::CMD_SKIP_ROM;
							ns.phase        = owm_pkg::PH_WR_LOW;
						end
						owm_pkg::STEP_CONVERT: begin
							ns.command_step = owm_pkg::STEP_RESET2;
							ns.shift_byte   = owm_pkg::CMD_CONVERT;
							ns.phase        = owm_pkg::PH_WR_LOW;
						end
						owm_pkg::STEP_RESET2: begin
							ns.command_step = owm_pkg::STEP_SECOND_RST;
							ns.bit_count    = st.bit_count;
							ns.phase        = owm_pkg::PH_RST_LEAD;
						end
						owm_pkg::STEP_SECOND_RST: begin
							ns.command_step = owm_pkg::STEP_READ_CMD;
							ns.shift_byte   = owm_pkg::CMD_SKIP_ROM;
							ns.phase        = owm_pkg::PH_WR_LOW;
						end
						owm_pkg::STEP_READ_CMD: begin
							ns.command_step = owm_pkg::STEP_START_RD;
							ns.shift_byte   = owm_pkg::CMD_READ_SP;
							ns.phase        = owm_pkg::PH_WR_LOW;
						end
						owm_pkg::STEP_START_RD: begin
							ns.command_step = owm_pkg::STEP_READING;
							ns.bytes_read   = 4'd0;
							ns.shift_byte   = 8'd0;
							ns.phase        = owm_pkg::PH_RD_LOW;
						end
						default: begin
							read_sum      = {1'b0, ns.bytes_read} + 5'd1;
							last          = read_sum >= 5'(SCRATCH_BYTES);
							emit          = 1'b1;
							emit_byte     = ns.shift_byte;
							emit_last     = last;
							ns.bytes_read = read_sum[3:0];
							if (last) begin
								ns.phase = owm_pkg::PH_IDLE;
								done     = 1'b1;
							end else begin
								ns.shift_byte = 8'd0;
								ns.phase      = owm_pkg::PH_RD_LOW;
							end
						end
					endcase
				end
			end
		end
	end

	// result of the tick
	always_comb begin
		r               = '0;
		r.drive_low     = drv;
		r.busy_res      = busy;
		r.done_res      = done;
		r.first_absent  = ns.absent_flags[0];
		r.second_absent = ns.absent_flags[1];
		if (emit) begin
			r.read_byte  = emit_byte;
			r.byte_valid = 1'b1;
			r.last_byte  = emit_last;
		end
	end

	assign nxt = ns;
	assign res = r;

endmodule
`default_nettype wire

[rtl/core/one_wire_master_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_master_sequencer
// Tick-stepped 1-Wire bus master with reset, byte write, byte read and a
// scratchpad read transaction.
// ----------------------------------------------------------------------------
// Each input transfer is one bus tick and yields exactly one result transfer.
// The block takes one tick per clock cycle while the result register can
// advance; a tick passes an input register and then the sequencer logic into
// a result register, from which its result is offered. While a result waits,
// a tick is still taken as long as the input register is free. The user must
// write timing registers only while no command is running and no tick or
// result is held inside the block; the block itself does not enforce this.
module one_wire_master_sequencer #(
	parameter int SCRATCH_BYTES = owm_pkg::ScratchBytesDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] operation,
	input  wire logic [7:0] write_data,
	input  wire logic       bus_level,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            drive_low,
	output logic            busy_res,
	output logic            done_res,
	output logic            first_absent,
	output logic            second_absent,
	output logic [7:0]      read_byte,
	output logic            byte_valid,
	output logic            last_byte,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_wdata
);

	owm_pkg::cfg_t   cfg;
	owm_pkg::state_t state_q;
	owm_pkg::state_t state_nxt;
	owm_pkg::item_t  item_s1;
	owm_pkg::res_t   res_nxt;
	owm_pkg::res_t   res_s2;
	logic            valid_s1;
	logic            valid_s2;
	logic            adv_s2;
	logic            step_en;

	owm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	owm_step #(
		.SCRATCH_BYTES (SCRATCH_BYTES)
	) u_step (
		.st   (state_q),
		.cfg  (cfg),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign step_en  = valid_s1 && adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.operation  <= operation;
			item_s1.write_data <= write_data;
			item_s1.bus_level  <= bus_level;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: owm_pkg::PH_IDLE, default: '0};
		end else if (step_en) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign drive_low     = res_s2.drive_low;
	assign busy_res      = res_s2.busy_res;
	assign done_res      = res_s2.done_res;
	assign first_absent  = res_s2.first_absent;
	assign second_absent = res_s2.second_absent;
	assign read_byte     = res_s2.read_byte;
	assign byte_valid    = res_s2.byte_valid;
	assign last_byte     = res_s2.last_byte;

	a_idle_counter_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == owm_pkg::PH_IDLE |-> state_q.tick_count == 8'd0)
		else $error("tick counter not clear while idle");

	a_drive_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_low |-> busy_res)
		else $error("line driven outside a command");

	a_done_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done without a running command");

	a_no_byte_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> read_byte == 8'd0 && !last_byte)
		else $error("read data without a completed byte");

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the 1-Wire bus master sequencer. Every tick transfer is run
// through a cycle-true predictor of the sequencer, and each result transfer is
// compared field by field with the oldest prediction. Directed commands cover
// resets with and without a device, byte writes and reads at the data
// extremes, scratchpad transactions and the widest and zero timing values.
// Random command streams follow under three sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SCRATCH = owm_pkg::ScratchBytesDefault;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_TICKS = 130;

	typedef logic [owm_pkg::NumRegs-1:0][7:0] timing_set_t;
	typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [7:0] write_data = '0;
	logic bus_level = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic drive_low, busy_res, done_res, first_absent, second_absent;
	logic [7:0] read_byte;
	logic byte_valid, last_byte;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int ticks_sent = 0;
	int mismatches = 0;
	int stall_cycles = 0;
	owm_pkg::res_t pending_results[$];
	owm_pkg::res_t seen, wanted;

	// predictor state
	logic [7:0] timing [owm_pkg::NumRegs];
	owm_pkg::phase_t ph;
	logic [7:0] tick_cnt;
	logic [2:0] bit_cnt;
	logic [7:0] shifter;
	owm_pkg::step_t step;
	logic [3:0] nbytes;
	logic [1:0] absent;
	logic [2:0] active_op;

	one_wire_master_sequencer #(.SCRATCH_BYTES(SCRATCH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.write_data(write_data),
		.bus_level(bus_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_low(drive_low),
		.busy_res(busy_res),
		.done_res(done_res),
		.first_absent(first_absent),
		.second_absent(second_absent),
		.read_byte(read_byte),
		.byte_valid(byte_valid),
		.last_byte(last_byte),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic timing_set_t default_timing();
		timing_set_t v;
		v[owm_pkg::REG_RESET_LOW] = 8'd120;
		v[owm_pkg::REG_PRESENCE_WAIT] = 8'd15;
		v[owm_pkg::REG_RESET_TAIL] = 8'd20;
		v[owm_pkg::REG_READ_SAMPLE] = 8'd2;
		v[owm_pkg::REG_READ_TAIL] = 8'd11;
		v[owm_pkg::REG_SHORT_LOW] = 8'd2;
		v[owm_pkg::REG_LONG_LOW] = 8'd10;
		return v;
	endfunction

	function automatic timing_set_t uniform_timing(input logic [7:0] ticks);
		timing_set_t v;
		for (int i = 0; i < owm_pkg::NumRegs; i++) v[i] = ticks;
		return v;
	endfunction

	function automatic timing_set_t random_timing(input int hi);
		timing_set_t v;
		for (int i = 0; i < owm_pkg::NumRegs; i++) v[i] = 8'($urandom_range(hi, 1));
		return v;
	endfunction

	function automatic void reset_model();
		timing_set_t v;
		v = default_timing();
		for (int i = 0; i < owm_pkg::NumRegs; i++) timing[i] = v[i];
		ph = owm_pkg::PH_IDLE;
		tick_cnt = '0;
		bit_cnt = '0;
		shifter = '0;
		step = owm_pkg::STEP_FIRST_SKIP;
		nbytes = '0;
		absent = '0;
		active_op = owm_pkg::OP_TICK;
	endfunction

	function automatic void start_reset();
		ph = owm_pkg::PH_RST_LEAD;
		tick_cnt = '0;
	endfunction

	function automatic void start_write(input logic [7:0] b);
		shifter = b;
		bit_cnt = '0;
		tick_cnt = '0;
		ph = owm_pkg::PH_WR_LOW;
	endfunction

	function automatic void start_read();
		shifter = '0;
		bit_cnt = '0;
		tick_cnt = '0;
		ph = owm_pkg::PH_RD_LOW;
	endfunction

	function automatic void finish_command(inout owm_pkg::res_t r);
		ph = owm_pkg::PH_IDLE;
		tick_cnt = '0;
		r.done_res = 1'b1;
	endfunction

	function automatic void show_byte(inout owm_pkg::res_t r, input logic last);
		r.read_byte = shifter;
		r.byte_valid = 1'b1;
		r.last_byte = last;
	endfunction

	// a reset, byte write or byte read has just completed
	function automatic void unit_done(inout owm_pkg::res_t r);
		logic last;
		if (active_op != owm_pkg::OP_XACT) begin
			if (active_op == owm_pkg::OP_READ) show_byte(r, 1'b1);
			finish_command(r);
		end else begin
			case (step)
				owm_pkg::STEP_FIRST_SKIP: begin
					step = owm_pkg::STEP_CONVERT;
					start_write(owm_pkg::CMD_SKIP_ROM);
				end
				owm_pkg::STEP_CONVERT: begin
					step = owm_pkg::STEP_RESET2;
					start_write(owm_pkg::CMD_CONVERT);
				end
				owm_pkg::STEP_RESET2: begin
					step = owm_pkg::STEP_SECOND_RST;
					start_reset();
				end
				owm_pkg::STEP_SECOND_RST: begin
					step = owm_pkg::STEP_READ_CMD;
					start_write(owm_pkg::CMD_SKIP_ROM);
				end
				owm_pkg::STEP_READ_CMD: begin
					step = owm_pkg::STEP_START_RD;
					start_write(owm_pkg::CMD_READ_SP);
				end
				owm_pkg::STEP_START_RD: begin
					step = owm_pkg::STEP_READING;
					nbytes = '0;
					start_read();
				end
				default: begin
					last = (int'(nbytes) + 1) >= SCRATCH;
					show_byte(r, last);
					nbytes = nbytes + 4'd1;
					if (last) finish_command(r);
					else start_read();
				end
			endcase
		end
	endfunction

	function automatic logic [7:0] phase_ticks();
		logic [7:0] d;
		case (ph)
			owm_pkg::PH_RST_LEAD: d = owm_pkg::RESET_LEAD_TICKS;
			owm_pkg::PH_RST_LOW: d = timing[owm_pkg::REG_RESET_LOW];
			owm_pkg::PH_RST_WAIT: d = timing[owm_pkg::REG_PRESENCE_WAIT];
			owm_pkg::PH_RST_TAIL: d = timing[owm_pkg::REG_RESET_TAIL];
			owm_pkg::PH_WR_LOW: d = shifter[0] ? timing[owm_pkg::REG_SHORT_LOW]
				: timing[owm_pkg::REG_LONG_LOW];
			owm_pkg::PH_WR_HIGH: d = shifter[0] ? timing[owm_pkg::REG_LONG_LOW]
				: timing[owm_pkg::REG_SHORT_LOW];
			owm_pkg::PH_RD_WAIT: d = timing[owm_pkg::REG_READ_SAMPLE];
			owm_pkg::PH_RD_TAIL: d = timing[owm_pkg::REG_READ_TAIL];
			default: d = 8'd1;
		endcase
		return (d == 8'd0) ? 8'd1 : d;
	endfunction

	// advances the predicted sequencer by one tick and returns its outputs
	function automatic owm_pkg::res_t bus_tick(input logic [2:0] op, input logic [7:0] wd,
			input logic lvl);
		owm_pkg::res_t r;
		logic [7:0] len;
		r = '0;
		if (ph == owm_pkg::PH_IDLE && op >= owm_pkg::OP_RESET && op <= owm_pkg::OP_XACT) begin
			active_op = op;
			absent = '0;
			step = owm_pkg::STEP_FIRST_SKIP;
			nbytes = '0;
			if (op == owm_pkg::OP_WRITE) start_write(wd);
			else if (op == owm_pkg::OP_READ) start_read();
			else start_reset();
		end
		if (ph != owm_pkg::PH_IDLE) begin
			r.busy_res = 1'b1;
			r.drive_low = (ph == owm_pkg::PH_RST_LOW || ph == owm_pkg::PH_WR_LOW ||
				ph == owm_pkg::PH_RD_LOW);
			len = phase_ticks();
			if (tick_cnt == 8'd0 && ph == owm_pkg::PH_RST_TAIL && lvl) begin
				if (active_op == owm_pkg::OP_XACT && step == owm_pkg::STEP_SECOND_RST)
					absent[1] = 1'b1;
				else absent[0] = 1'b1;
			end
			if (tick_cnt == 8'd0 && ph == owm_pkg::PH_RD_TAIL) shifter = {lvl, shifter[7:1]};
			tick_cnt = tick_cnt + 8'd1;
			if (tick_cnt >= len) begin
				tick_cnt = '0;
				case (ph)
					owm_pkg::PH_RST_LEAD: ph = owm_pkg::PH_RST_LOW;
					owm_pkg::PH_RST_LOW: ph = owm_pkg::PH_RST_WAIT;
					owm_pkg::PH_RST_WAIT: ph = owm_pkg::PH_RST_TAIL;
					owm_pkg::PH_WR_LOW: ph = owm_pkg::PH_WR_HIGH;
					owm_pkg::PH_RD_LOW: ph = owm_pkg::PH_RD_WAIT;
					owm_pkg::PH_RD_WAIT: ph = owm_pkg::PH_RD_TAIL;
					owm_pkg::PH_WR_HIGH: begin
						shifter = shifter >> 1;
						bit_cnt = bit_cnt + 3'd1;
						if (bit_cnt == 3'd0) unit_done(r);
						else ph = owm_pkg::PH_WR_LOW;
					end
					owm_pkg::PH_RD_TAIL: begin
						bit_cnt = bit_cnt + 3'd1;
						if (bit_cnt == 3'd0) unit_done(r);
						else ph = owm_pkg::PH_RD_LOW;
					end
					default: unit_done(r);
				endcase
			end
		end
		r.first_absent = absent[0];
		r.second_absent = absent[1];
		return r;
	endfunction

	function automatic logic pick_level(input line_mode_t mode);
		case (mode)
			LINE_LOW: return 1'b0;
			LINE_HIGH: return 1'b1;
			default: return 1'($urandom_range(1));
		endcase
	endfunction

	task automatic send_tick(input logic [2:0] op, input logic [7:0] wd, input logic lvl);
		logic taken;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		operation <= op;
		write_data <= wd;
		bus_level <= lvl;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(bus_tick(op, wd, lvl));
		ticks_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// commands issued while busy are random and must be ignored
	task automatic run_command(input logic [2:0] op, input logic [7:0] wd,
			input line_mode_t mode);
		send_tick(op, wd, pick_level(mode));
		while (ph != owm_pkg::PH_IDLE)
			send_tick(3'($urandom_range(7)), 8'($urandom), pick_level(mode));
	endtask

	task automatic program_timing(input timing_set_t v);
		while (ph != owm_pkg::PH_IDLE)
			send_tick(owm_pkg::OP_TICK, 8'($urandom), 1'($urandom_range(1)));
		wait_drained();
		for (int i = 0; i < owm_pkg::NumRegs; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= owm_pkg::reg_idx_t'(i);
			cfg_wdata <= v[i];
			@(posedge clk);
			timing[i] = v[i];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] have);
		if (have !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h got %0h", $realtime, name, want, have);
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = {drive_low, busy_res, done_res, first_absent, second_absent,
				read_byte, byte_valid, last_byte};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result transfer with nothing expected", $realtime);
			end else begin
				wanted = pending_results.pop_front();
				check_field("drive_low", 8'(wanted.drive_low), 8'(seen.drive_low));
				check_field("busy_res", 8'(wanted.busy_res), 8'(seen.busy_res));
				check_field("done_res", 8'(wanted.done_res), 8'(seen.done_res));
				check_field("first_absent", 8'(wanted.first_absent), 8'(seen.first_absent));
				check_field("second_absent", 8'(wanted.second_absent), 8'(seen.second_absent));
				check_field("read_byte", wanted.read_byte, seen.read_byte);
				check_field("byte_valid", 8'(wanted.byte_valid), 8'(seen.byte_valid));
				check_field("last_byte", 8'(wanted.last_byte), 8'(seen.last_byte));
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("one_wire_master_sequencer regression: fail");
				$finish;
			end
		end
	end

	task automatic test_idle_ticks();
		send_tick(owm_pkg::OP_TICK, 8'h00, 1'b0);
		send_tick(owm_pkg::OP_TICK, 8'hFF, 1'b1);
		for (int c = int'(owm_pkg::OP_XACT) + 1; c < 8; c++)
			send_tick(3'(c), 8'($urandom), 1'b1);
	endtask

	task automatic test_bus_reset();
		run_command(owm_pkg::OP_RESET, 8'h00, LINE_LOW);
		run_command(owm_pkg::OP_RESET, 8'hFF, LINE_HIGH);
		// absent flag held while idle
		send_tick(owm_pkg::OP_TICK, 8'h00, 1'b0);
	endtask

	task automatic test_write_byte();
		timing_set_t v;
		v = uniform_timing(8'd2);
		v[owm_pkg::REG_SHORT_LOW] = 8'd1;
		v[owm_pkg::REG_LONG_LOW] = 8'd3;
		program_timing(v);
		run_command(owm_pkg::OP_WRITE, 8'h00, LINE_RANDOM);
		run_command(owm_pkg::OP_WRITE, 8'hFF, LINE_RANDOM);
		run_command(owm_pkg::OP_WRITE, 8'hA5, LINE_RANDOM);
	endtask

	task automatic test_read_byte();
		program_timing(uniform_timing(8'd1));
		run_command(owm_pkg::OP_READ, 8'h00, LINE_LOW);
		run_command(owm_pkg::OP_READ, 8'hFF, LINE_HIGH);
		run_command(owm_pkg::OP_READ, 8'h3C, LINE_RANDOM);
	endtask

	task automatic test_transaction();
		run_command(owm_pkg::OP_XACT, 8'h00, LINE_HIGH);
		run_command(owm_pkg::OP_XACT, 8'h5A, LINE_RANDOM);
	endtask

	task automatic test_timing_extremes();
		timing_set_t v;
		v = uniform_timing(8'd1);
		v[owm_pkg::REG_RESET_LOW] = 8'd255;
		// zero durations act as one tick
		v[owm_pkg::REG_PRESENCE_WAIT] = 8'd0;
		v[owm_pkg::REG_READ_SAMPLE] = 8'd0;
		v[owm_pkg::REG_SHORT_LOW] = 8'd0;
		program_timing(v);
		run_command(owm_pkg::OP_RESET, 8'h00, LINE_HIGH);
		run_command(owm_pkg::OP_WRITE, 8'h5A, LINE_RANDOM);
		run_command(owm_pkg::OP_READ, 8'h00, LINE_RANDOM);
		program_timing(default_timing());
	endtask

	task automatic test_random_traffic(input int n_ticks);
		int first_tick;
		int pick;
		line_mode_t mode;
		first_tick = ticks_sent;
		program_timing(random_timing(4));
		while (ticks_sent - first_tick < n_ticks) begin
			if ($urandom_range(5) == 0) program_timing(random_timing($urandom_range(1) ? 2 : 4));
			pick = $urandom_range(99);
			mode = ($urandom_range(4) == 0) ? line_mode_t'($urandom_range(1)) : LINE_RANDOM;
			if (pick < 10) begin
				// idle noise: tick only and unused codes
				pick = $urandom_range(3);
				send_tick((pick == 0) ? owm_pkg::OP_TICK : 3'(int'(owm_pkg::OP_XACT) + pick),
					8'($urandom), pick_level(mode));
			end else if (pick < 38) run_command(owm_pkg::OP_RESET, 8'($urandom), mode);
			else if (pick < 68) run_command(owm_pkg::OP_WRITE, 8'($urandom), mode);
			else if (pick < 94) run_command(owm_pkg::OP_READ, 8'($urandom), mode);
			else run_command(owm_pkg::OP_XACT, 8'($urandom), mode);
		end
	endtask

	initial begin
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 77;
		test_idle_ticks();
		test_bus_reset();
		test_write_byte();
		test_read_byte();
		test_transaction();
		test_random_traffic(RANDOM_TICKS);

		send_idle_pct = 77;
		recv_idle_pct = 24;
		test_random_traffic(RANDOM_TICKS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_timing_extremes();
		test_random_traffic(RANDOM_TICKS);

		wait_drained();
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("one_wire_master_sequencer regression: pass");
		end else begin
			$display("one_wire_master_sequencer regression: fail");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/owm_pkg.sv
rtl/core/owm_cfg.sv
rtl/core/owm_step.sv
rtl/core/one_wire_master_sequencer.sv
tb/testbench.sv
